FILE: src/sketch_command_decoder_assert.svh
// Assertion macros shared by the sketch command decoder modules.
// Needs nothing else; each macro takes a clock and an active-low reset.
`ifndef SKETCH_COMMAND_DECODER_ASSERT_SVH
`define SKETCH_COMMAND_DECODER_ASSERT_SVH

// Same-cycle implication.
`define SCD_ASSERT_NOW(label, aclk, arst_n, ante, cons) \
  label: assert property (@(posedge aclk) disable iff (!arst_n) (ante) |-> (cons)) \
    else $error("sketch command decoder: check failed");

// Next-cycle implication.
`define SCD_ASSERT_NEXT(label, aclk, arst_n, ante, cons) \
  label: assert property (@(posedge aclk) disable iff (!arst_n) (ante) |=> (cons)) \
    else $error("sketch command decoder: check failed");

`endif

FILE: src/scd_pkg.sv
// Shared types and operation codes of the sketch command decoder.
// No dependencies.
package scd_pkg;

  // Decoded operation kinds; values match the extended selector field.
  localparam logic [2:0] OP_DX     = 3'd0;
  localparam logic [2:0] OP_DY     = 3'd1;
  localparam logic [2:0] OP_PAUSE  = 3'd2;
  localparam logic [2:0] OP_PEN    = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_KEY    = 3'd5;
  localparam logic [2:0] OP_COLOUR = 3'd6;
  localparam logic [2:0] OP_NOP    = 3'd7;

  localparam logic [31:0] DEFAULT_COLOUR = 32'd255;

  // One decoded operation as it travels from front to back.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
  } op_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: src/scd_front.sv
// Front end: takes stream bytes, gathers extended operands and emits decoded operations.
// Depends on scd_pkg.
module scd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_stream_byte,
  input  scd_pkg::q_status_t  q_stat,
  output logic                op_valid,
  output scd_pkg::op_t        op
);

  localparam logic [1:0] HDR_DX    = 2'd0;
  localparam logic [1:0] HDR_DY    = 2'd1;
  localparam logic [1:0] HDR_PAUSE = 2'd2;
  localparam logic [1:0] HDR_EXT   = 2'd3;

  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic [2:0]  op_len_r, op_len_nxt;
  logic [2:0]  pending_r, pending_nxt;
  logic [31:0] acc_r, acc_nxt;

  logic        accept;
  logic [31:0] acc_shift;
  logic [31:0] sval;
  logic [5:0]  low6;
  logic [2:0]  hdr_len;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  assign acc_shift = {acc_r[23:0], in_stream_byte};
  assign low6      = in_stream_byte[5:0];
  assign hdr_len   = (in_stream_byte[5:4] == 2'b11) ? 3'd4 : {1'b0, in_stream_byte[5:4]};

  always_comb begin
    case (op_len_r)
      3'd1:    sval = {{24{acc_shift[7]}}, acc_shift[7:0]};
      3'd2:    sval = {{16{acc_shift[15]}}, acc_shift[15:0]};
      default: sval = acc_shift;
    endcase
  end

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    op_len_nxt     = op_len_r;
    pending_nxt    = pending_r;
    acc_nxt        = acc_r;
    op_valid       = 1'b0;
    op             = '0;
    if (accept) begin
      if (bytes_left_r != 3'd0) begin
        acc_nxt        = acc_shift;
        bytes_left_nxt = bytes_left_r - 3'd1;
        if (bytes_left_r == 3'd1) begin
          op_valid = (pending_r != scd_pkg::OP_NOP);
          op.kind  = pending_r;
          if (pending_r == scd_pkg::OP_DX || pending_r == scd_pkg::OP_DY) begin
            op.value = sval;
          end else begin
            op.value = acc_shift;
          end
        end
      end else begin
        case (in_stream_byte[7:6])
          HDR_DX: begin
            op_valid = 1'b1;
            op.kind  = scd_pkg::OP_DX;
            op.value = {{26{low6[5]}}, low6};
          end
          HDR_DY: begin
            op_valid = 1'b1;
            op.kind  = scd_pkg::OP_DY;
            op.value = {{26{low6[5]}}, low6};
          end
          HDR_PAUSE: begin
            op_valid = 1'b1;
            op.kind  = scd_pkg::OP_PAUSE;
            op.value = {26'd0, low6};
          end
          HDR_EXT: begin
            op_len_nxt     = hdr_len;
            pending_nxt    = in_stream_byte[2:0];
            acc_nxt        = '0;
            bytes_left_nxt = hdr_len;
            // A zero-length command runs at once with a zero operand.
            if (hdr_len == 3'd0) begin
              op_valid = (in_stream_byte[2:0] != scd_pkg::OP_NOP);
              op.kind  = in_stream_byte[2:0];
              op.value = '0;
            end
          end
          default: begin
            op_valid = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      op_len_r     <= '0;
      pending_r    <= '0;
      acc_r        <= '0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      op_len_r     <= op_len_nxt;
      pending_r    <= pending_nxt;
      acc_r        <= acc_nxt;
    end
  end

endmodule

FILE: src/scd_queue.sv
// Short operation queue between the decoder front and the execution back.
// Depends on scd_pkg and sketch_command_decoder_assert.svh.
`include "sketch_command_decoder_assert.svh"

module scd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  scd_pkg::op_t        push_op,
  input  logic                pop,
  output scd_pkg::op_t        head_op,
  output scd_pkg::q_status_t  q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  scd_pkg::op_t entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_op      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  `SCD_ASSERT_NOW(a_push_not_full, clk, rst_n, push, !q_stat.full)
  `SCD_ASSERT_NOW(a_pop_not_empty, clk, rst_n, pop, !q_stat.empty)
  `SCD_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))

endmodule

FILE: src/scd_back.sv
// Back end: executes decoded operations on the pen state and registers the results.
// Depends on scd_pkg and sketch_command_decoder_assert.svh.
`include "sketch_command_decoder_assert.svh"

module scd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  scd_pkg::op_t        head_op,
  input  scd_pkg::q_status_t  q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_command,
  output logic signed [31:0]  out_from_x,
  output logic signed [31:0]  out_from_y,
  output logic signed [31:0]  out_to_x,
  output logic signed [31:0]  out_to_y,
  output logic [31:0]         out_line_colour,
  output logic [31:0]         out_pause_amount
);

  localparam logic [1:0] CMD_LINE  = 2'd0;
  localparam logic [1:0] CMD_PAUSE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_KEY   = 2'd3;

  logic [31:0] pos_x_r, pos_x_nxt;
  logic [31:0] pos_y_r, pos_y_nxt;
  logic [31:0] prev_x_r, prev_x_nxt;
  logic [31:0] prev_y_r, prev_y_nxt;
  logic        pen_r, pen_nxt;
  logic [31:0] colour_r, colour_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [31:0] from_x_r, from_x_nxt;
  logic [31:0] from_y_r, from_y_nxt;
  logic [31:0] to_x_r, to_x_nxt;
  logic [31:0] to_y_r, to_y_nxt;
  logic [31:0] colr_out_r, colr_out_nxt;
  logic [31:0] pause_r, pause_nxt;

  logic        load;
  logic [31:0] sum_x, sum_y;

  assign pop   = !q_stat.empty && (!out_valid_r || !out_stall);
  assign sum_x = pos_x_r + head_op.value;
  assign sum_y = pos_y_r + head_op.value;

  always_comb begin
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    prev_x_nxt   = prev_x_r;
    prev_y_nxt   = prev_y_r;
    pen_nxt      = pen_r;
    colour_nxt   = colour_r;
    load         = 1'b0;
    cmd_nxt      = CMD_LINE;
    from_x_nxt   = '0;
    from_y_nxt   = '0;
    to_x_nxt     = '0;
    to_y_nxt     = '0;
    colr_out_nxt = '0;
    pause_nxt    = '0;
    if (pop) begin
      case (head_op.kind)
        scd_pkg::OP_DX: begin
          pos_x_nxt = sum_x;
        end
        scd_pkg::OP_DY: begin
          pos_y_nxt  = sum_y;
          prev_x_nxt = pos_x_r;
          prev_y_nxt = sum_y;
          if (pen_r) begin
            load         = 1'b1;
            cmd_nxt      = CMD_LINE;
            from_x_nxt   = prev_x_r;
            from_y_nxt   = prev_y_r;
            to_x_nxt     = pos_x_r;
            to_y_nxt     = sum_y;
            colr_out_nxt = colour_r;
          end
        end
        scd_pkg::OP_PAUSE: begin
          load      = 1'b1;
          cmd_nxt   = CMD_PAUSE;
          pause_nxt = head_op.value;
        end
        scd_pkg::OP_PEN: begin
          pen_nxt = !pen_r;
        end
        scd_pkg::OP_CLEAR: begin
          load    = 1'b1;
          cmd_nxt = CMD_CLEAR;
        end
        scd_pkg::OP_KEY: begin
          load    = 1'b1;
          cmd_nxt = CMD_KEY;
        end
        scd_pkg::OP_COLOUR: begin
          colour_nxt = head_op.value;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      pen_r       <= 1'b0;
      colour_r    <= scd_pkg::DEFAULT_COLOUR;
      out_valid_r <= 1'b0;
    end else begin
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      pen_r       <= pen_nxt;
      colour_r    <= colour_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r      <= cmd_nxt;
      from_x_r   <= from_x_nxt;
      from_y_r   <= from_y_nxt;
      to_x_r     <= to_x_nxt;
      to_y_r     <= to_y_nxt;
      colr_out_r <= colr_out_nxt;
      pause_r    <= pause_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command      = cmd_r;
  assign out_from_x       = from_x_r;
  assign out_from_y       = from_y_r;
  assign out_to_x         = to_x_r;
  assign out_to_y         = to_y_r;
  assign out_line_colour  = colr_out_r;
  assign out_pause_amount = pause_r;

  `SCD_ASSERT_NEXT(a_pen_toggles, clk, rst_n,
    pop && head_op.kind == scd_pkg::OP_PEN, pen_r != $past(pen_r))
  `SCD_ASSERT_NEXT(a_line_emitted, clk, rst_n,
    pop && head_op.kind == scd_pkg::OP_DY && pen_r, out_valid_r && cmd_r == CMD_LINE)

endmodule

FILE: src/sketch_command_decoder.sv
// Top level of the sketch command decoder: a byte-stream turtle-graphics decoder.
// Depends on scd_pkg, scd_front, scd_queue, scd_back and sketch_command_decoder_assert.svh.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  in_stream_byte (one header or operand byte)
//   out_     output     out_valid/out_stall  out_command, out_from_x/y, out_to_x/y,
//                                            out_line_colour, out_pause_amount
//
// One byte is accepted every cycle while the operation queue has room; the rate is set by
// the front decoder, which decodes each byte combinationally as it is accepted.
// A result reaches the out_ ports through the queue entry written when its byte is taken
// and the output register, loaded when the execution stage pops that entry.
// Reset is synchronous: it clears position, pen and parser state and loads DEFAULT_COLOUR.
// While the output register waits on out_stall the queue fills, and in_stall rises only
// once all QUEUE_DEPTH entries are taken.
module sketch_command_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_stream_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_command,
  output logic signed [31:0] out_from_x,
  output logic signed [31:0] out_from_y,
  output logic signed [31:0] out_to_x,
  output logic signed [31:0] out_to_y,
  output logic [31:0]        out_line_colour,
  output logic [31:0]        out_pause_amount
);

  // Operations decoded by the front and waiting for the back.
  scd_pkg::op_t       push_op;
  scd_pkg::op_t       head_op;
  scd_pkg::q_status_t q_stat;
  logic               push;
  logic               pop;

  // The front classifies each byte and gathers extended operands. Only bytes that
  // complete an operation other than OP_NOP push an entry; operand bytes in flight push nothing.
  scd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .q_stat         (q_stat),
    .op_valid       (push),
    .op             (push_op)
  );

  // The queue keeps operations in stream order so that moves without a result still
  // update the position before any later line is drawn.
  scd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .q_stat  (q_stat)
  );

  // The back owns the position, previous point, pen and colour. It pops one operation
  // a cycle whenever the output register is empty or being taken.
  scd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_op          (head_op),
    .q_stat           (q_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_from_x       (out_from_x),
    .out_from_y       (out_from_y),
    .out_to_x         (out_to_x),
    .out_to_y         (out_to_y),
    .out_line_colour  (out_line_colour),
    .out_pause_amount (out_pause_amount)
  );

endmodule

FILE: sim/sketch_command_decoder_check.sv
// Header and opcode names for the sketch command decoder testbench, and the checker
// that models the decoder and scores its results. Depends on scd_pkg.
package scd_test_pkg;

  // Opcode in the top two bits of a header byte.
  typedef enum logic [1:0] {HDR_DX, HDR_DY, HDR_PAUSE, HDR_EXT} hdr_op_e;

  // Operand length field of an extended header; the last code stands for four bytes.
  typedef enum logic [1:0] {LEN_0, LEN_1, LEN_2, LEN_4} len_code_e;

endpackage

module sketch_command_decoder_check
  import scd_pkg::*, scd_test_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_stream_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_command,
  input  logic signed [31:0] out_from_x,
  input  logic signed [31:0] out_from_y,
  input  logic signed [31:0] out_to_x,
  input  logic signed [31:0] out_to_y,
  input  logic [31:0]        out_line_colour,
  input  logic [31:0]        out_pause_amount,
  output int unsigned        mismatches,
  output int unsigned        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {CMD_LINE, CMD_PAUSE, CMD_CLEAR, CMD_KEY} sketch_cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] from_x;
    logic [31:0] from_y;
    logic [31:0] to_x;
    logic [31:0] to_y;
    logic [31:0] line_colour;
    logic [31:0] pause_amount;
  } sketch_result_t;

  // Turtle state as the decoder should hold it.
  logic [31:0] pos_x, pos_y, prev_x, prev_y, draw_colour, operand_acc;
  logic        pen_down;
  logic [2:0]  bytes_left, operand_length, pending_op;

  sketch_result_t expected_results[$];
  int unsigned    error_count = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic apply_op(input logic [2:0] sel, input logic [31:0] delta,
                          input logic [31:0] raw);
    sketch_result_t r;
    r = '0;
    case (sel)
      OP_DX: pos_x = pos_x + delta;
      OP_DY: begin
        pos_y = pos_y + delta;
        if (pen_down) begin
          r.command     = CMD_LINE;
          r.from_x      = prev_x;
          r.from_y      = prev_y;
          r.to_x        = pos_x;
          r.to_y        = pos_y;
          r.line_colour = draw_colour;
          expected_results.push_back(r);
        end
        prev_x = pos_x;
        prev_y = pos_y;
      end
      OP_PAUSE: begin
        r.command      = CMD_PAUSE;
        r.pause_amount = raw;
        expected_results.push_back(r);
      end
      OP_PEN: pen_down = !pen_down;
      OP_CLEAR: begin
        r.command = CMD_CLEAR;
        expected_results.push_back(r);
      end
      OP_KEY: begin
        r.command = CMD_KEY;
        expected_results.push_back(r);
      end
      OP_COLOUR: draw_colour = raw;
      OP_NOP: ;
    endcase
  endtask

  // Short operands are sign-extended by width; the 4-byte and empty operands pass as is.
  task automatic finish_extended();
    logic [31:0] sval;
    case (operand_length)
      3'd1:    sval = {{24{operand_acc[7]}}, operand_acc[7:0]};
      3'd2:    sval = {{16{operand_acc[15]}}, operand_acc[15:0]};
      default: sval = operand_acc;
    endcase
    apply_op(pending_op, sval, operand_acc);
  endtask

  task automatic follow_byte(input logic [7:0] b);
    logic [31:0] short_delta;
    short_delta = {{26{b[5]}}, b[5:0]};
    if (bytes_left != 3'd0) begin
      operand_acc = {operand_acc[23:0], b};
      bytes_left  = bytes_left - 3'd1;
      if (bytes_left == 3'd0) finish_extended();
    end else begin
      case (hdr_op_e'(b[7:6]))
        HDR_DX:    apply_op(OP_DX, short_delta, 32'd0);
        HDR_DY:    apply_op(OP_DY, short_delta, 32'd0);
        HDR_PAUSE: apply_op(OP_PAUSE, 32'd0, {26'd0, b[5:0]});
        HDR_EXT: begin
          operand_length = (len_code_e'(b[5:4]) == LEN_4) ? 3'd4 : {1'b0, b[5:4]};
          pending_op     = b[2:0];
          operand_acc    = '0;
          bytes_left     = operand_length;
          if (operand_length == 3'd0) finish_extended();
        end
      endcase
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $realtime, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    sketch_result_t want;
    if (!rst_n) begin
      pos_x          = '0;
      pos_y          = '0;
      prev_x         = '0;
      prev_y         = '0;
      pen_down       = 1'b0;
      draw_colour    = DEFAULT_COLOUR;
      bytes_left     = '0;
      operand_length = '0;
      pending_op     = '0;
      operand_acc    = '0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, command %0d", $realtime,
                   out_command);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("command", {30'd0, want.command}, {30'd0, out_command});
          check_field("from_x", want.from_x, out_from_x);
          check_field("from_y", want.from_y, out_from_y);
          check_field("to_x", want.to_x, out_to_x);
          check_field("to_y", want.to_y, out_to_y);
          check_field("line_colour", want.line_colour, out_line_colour);
          check_field("pause_amount", want.pause_amount, out_pause_amount);
        end
      end
      if (in_valid && !in_stall) follow_byte(in_stream_byte);
    end
    mismatches  <= error_count;
    outstanding <= expected_results.size();
  end

endmodule

FILE: sim/sketch_command_decoder_test.sv
// Top of the sketch command decoder testbench: clock, reset, byte stimulus, receiver stalls
// and the verdict. Depends on scd_pkg, scd_test_pkg and sketch_command_decoder_check.
module sketch_command_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Directed bytes come first; random commands are appended until the stream holds
  // at least this many bytes.
  localparam int STREAM_LENGTH = 1930;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_stream_byte = 8'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_command;
  logic signed [31:0] out_from_x;
  logic signed [31:0] out_from_y;
  logic signed [31:0] out_to_x;
  logic signed [31:0] out_to_y;
  logic [31:0]        out_line_colour;
  logic [31:0]        out_pause_amount;
  int unsigned        mismatches;
  int unsigned        outstanding;

  logic [7:0] stream_bytes[$];

  sketch_command_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_from_x       (out_from_x),
    .out_from_y       (out_from_y),
    .out_to_x         (out_to_x),
    .out_to_y         (out_to_y),
    .out_line_colour  (out_line_colour),
    .out_pause_amount (out_pause_amount)
  );

  // The checker sees both channels exactly as the block does and keeps its own
  // model of the turtle; it reports the mismatch count and the results still due.
  sketch_command_decoder_check u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_from_x       (out_from_x),
    .out_from_y       (out_from_y),
    .out_to_x         (out_to_x),
    .out_to_y         (out_to_y),
    .out_line_colour  (out_line_colour),
    .out_pause_amount (out_pause_amount),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Reset is held low from the start and released once, for good.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [7:0] short_byte(scd_test_pkg::hdr_op_e op, logic [5:0] arg);
    return {op, arg};
  endfunction

  // The spare bit between the length and the selector must be ignored by the block,
  // so the stimulus sets it now and then.
  function automatic logic [7:0] ext_header(scd_test_pkg::len_code_e len, logic spare,
                                            logic [2:0] sel);
    return {scd_test_pkg::HDR_EXT, len, spare, sel};
  endfunction

  // One random command. Most are well formed with random content: short moves and
  // pauses, and extended commands with their operand bytes. About one in ten is a
  // raw random byte, which may open an extended command that swallows what follows.
  // Pen toggles are favored so that the pen spends a good share of time down.
  task automatic add_random_command();
    int                      pick;
    int                      operand_bytes;
    scd_test_pkg::len_code_e len;
    logic [2:0]              sel;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      stream_bytes.push_back(8'($urandom));
    end else if (pick < 40) begin
      stream_bytes.push_back(short_byte(($urandom_range(0, 1) == 1) ? scd_test_pkg::HDR_DY
                                                                    : scd_test_pkg::HDR_DX,
                                        6'($urandom)));
    end else if (pick < 50) begin
      stream_bytes.push_back(short_byte(scd_test_pkg::HDR_PAUSE, 6'($urandom)));
    end else begin
      len = scd_test_pkg::len_code_e'($urandom_range(0, 3));
      sel = ($urandom_range(0, 2) == 0) ? scd_pkg::OP_PEN : 3'($urandom);
      stream_bytes.push_back(ext_header(len, 1'($urandom), sel));
      operand_bytes = (len == scd_test_pkg::LEN_4) ? 4 : int'(len);
      repeat (operand_bytes) stream_bytes.push_back(8'($urandom));
    end
  endtask

  // Sender. The byte stream is built up front, then offered in bursts of random
  // length separated by random gaps; a gap of zero runs two bursts together.
  initial begin
    int burst;
    int gap;
    int guard;

    // Directed opening. Pen down first, so that DY moves draw lines.
    stream_bytes.push_back(ext_header(scd_test_pkg::LEN_0, 1'b0, scd_pkg::OP_PEN));
    // Short moves at both ends of the 6-bit operand: +31, -32, and -1.
    stream_bytes.push_back(short_byte(scd_test_pkg::HDR_DX, 6'h1F));
    stream_bytes.push_back(short_byte(scd_test_pkg::HDR_DX, 6'h20));
    stream_bytes.push_back(short_byte(scd_test_pkg::HDR_DY, 6'h1F));
    stream_bytes.push_back(short_byte(scd_test_pkg::HDR_DY, 6'h3F));
    stream_bytes.push_back(short_byte(scd_test_pkg::HDR_DY, 6'h20));
    // Shortest and longest short pause.
    stream_bytes.push_back(short_byte(scd_test_pkg::HDR_PAUSE, 6'h00));
    stream_bytes.push_back(short_byte(scd_test_pkg::HDR_PAUSE, 6'h3F));
    // One-byte operand sign-extended from bit 7.
    stream_bytes.push_back(ext_header(scd_test_pkg::LEN_1, 1'b0, scd_pkg::OP_DX));
    stream_bytes.push_back(8'h80);
    // Two-byte operand sign-extended from bit 15, drawing a line.
    stream_bytes.push_back(ext_header(scd_test_pkg::LEN_2, 1'b0, scd_pkg::OP_DY));
    stream_bytes.push_back(8'h80);
    stream_bytes.push_back(8'h00);
    // Colour set takes the operand unsigned; the next line must carry it.
    stream_bytes.push_back(ext_header(scd_test_pkg::LEN_2, 1'b0, scd_pkg::OP_COLOUR));
    stream_bytes.push_back(8'h80);
    stream_bytes.push_back(8'h01);
    // Empty operand: a DY by zero that still draws.
    stream_bytes.push_back(ext_header(scd_test_pkg::LEN_0, 1'b0, scd_pkg::OP_DY));
    // Four-byte pause with every bit set, spare bit set.
    stream_bytes.push_back(ext_header(scd_test_pkg::LEN_4, 1'b1, scd_pkg::OP_PAUSE));
    repeat (4) stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(ext_header(scd_test_pkg::LEN_0, 1'b0, scd_pkg::OP_CLEAR));
    stream_bytes.push_back(ext_header(scd_test_pkg::LEN_0, 1'b1, scd_pkg::OP_KEY));
    // The do-nothing selector still eats its operand byte.
    stream_bytes.push_back(ext_header(scd_test_pkg::LEN_1, 1'b0, scd_pkg::OP_NOP));
    stream_bytes.push_back(8'hAA);
    // Pen up again: a DY now moves without drawing.
    stream_bytes.push_back(ext_header(scd_test_pkg::LEN_0, 1'b0, scd_pkg::OP_PEN));
    stream_bytes.push_back(short_byte(scd_test_pkg::HDR_DY, 6'h05));

    while (stream_bytes.size() < STREAM_LENGTH) add_random_command();

    wait (rst_n);
    @(posedge clk);

    burst = $urandom_range(1, 30);
    foreach (stream_bytes[i]) begin
      in_valid       <= 1'b1;
      in_stream_byte <= stream_bytes[i];
      // The item goes through at the first edge where the block is not stalling.
      @(posedge clk);
      while (in_stall) @(posedge clk);
      burst--;
      if (burst == 0) begin
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                            : $urandom_range(1, 30);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;

    // Let the checker register the expectation of the last item. Then wait, within a
    // bound, for every expected result, and then longer to catch any stray result the
    // block might still produce.
    @(posedge clk);
    guard = 0;
    while (outstanding != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver. Stall behavior changes with each segment of random length: never,
  // lightly, heavily, or on alternate cycles. Two segments are instead a long
  // hold-off, during which the sender keeps offering items so that the two-entry
  // queue fills and the block has to stall its input.
  initial begin
    int span;
    int mode;
    int segment;
    segment = 0;
    wait (rst_n);
    forever begin
      span = $urandom_range(20, 200);
      mode = $urandom_range(0, 3);
      segment++;
      if (segment == 8 || segment == 30) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        repeat (span) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= !out_stall;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // A correct run takes well under a tenth of this, even with every stall.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
